### hw/rtl/upd_pkg.sv
package upd_pkg;

    // Character codes used by the decoder.
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;

    // One input item produces at most this many results.
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned COUNT_W     = 2;

    // Result queue: a power of two, at least MAX_RESULTS entries.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned PTR_W       = 2;
    localparam int unsigned FILL_W      = 3;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PERCENT = 2'd1,
        PH_PENDING = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        result_t [MAX_RESULTS-1:0] item;
    } bundle_t;

    // Low four bits hold the digit value; bit 4 is set when the byte is not a hex digit.
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - CH_0;
            return {1'b0, v[3:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = c - CH_UA + 8'd10;
            return {1'b0, v[3:0]};
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = c - CH_LA + 8'd10;
            return {1'b0, v[3:0]};
        end
        return 5'h10;
    endfunction

    // Output for a byte seen with no escape open, where a percent cannot open one.
    function automatic logic [7:0] plain_out(input logic [7:0] c);
        if (c == CH_PERCENT) begin
            return CH_QUEST;
        end else if (c == CH_PLUS) begin
            return CH_SPACE;
        end
        return c;
    endfunction

endpackage

### hw/rtl/url_percent_decoder.sv
// Path: an item is registered in the input stage and its results in the result queue.
// Throughput: one input item per cycle while each item yields at most one result and
// m_ready stays high; the result queue drains one item per cycle while m_ready is high,
// so an item yielding two or three results can hold the input side until the queue has room.
// Reset: aresetn is synchronous and active low; it empties the input stage and the
// result queue and leaves no escape pending.
module url_percent_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    // Input stage: holds one accepted item until the decoder can pass all of its
    // results into the queue.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    upd_pkg::bundle_t results;
    logic             space_ok;
    logic             advance;
    logic             s_accept;

    // The held item moves on only when the queue has room for every result it makes,
    // so the escape state and the queue always advance together.
    assign advance  = in_valid_reg && space_ok;
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign in_valid_next = s_accept || (in_valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_in_byte;
            in_last_reg <= s_in_last;
        end
    end

    // Escape tracking and the decode of one item into up to three results.
    upd_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item_byte (in_byte_reg),
        .item_last (in_last_reg),
        .results   (results)
    );

    // Small result queue that parts the decoder from the output handshake.
    upd_result_queue u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_bundle (results),
        .push        (advance),
        .space_ok    (space_ok),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_byte    (m_out_byte),
        .out_last    (m_out_last)
    );

endmodule

### hw/rtl/upd_decoder.sv
module upd_decoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [7:0]        item_byte,
    input  logic              item_last,
    output upd_pkg::bundle_t  results
);

    upd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      pending_reg, pending_next;

    logic [4:0] hi_nib;
    logic [4:0] lo_nib;
    logic       pair_ok;
    logic       b_pct;
    logic       p_pct;

    assign hi_nib  = upd_pkg::hex_nibble(pending_reg);
    assign lo_nib  = upd_pkg::hex_nibble(item_byte);
    assign pair_ok = !hi_nib[4] && !lo_nib[4];
    assign b_pct   = (item_byte == upd_pkg::CH_PERCENT);
    assign p_pct   = (pending_reg == upd_pkg::CH_PERCENT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= upd_pkg::PH_IDLE;
            pending_reg <= 8'h00;
        end else if (advance) begin
            phase_reg   <= phase_next;
            pending_reg <= pending_next;
        end
    end

    // Next escape state.
    always_comb begin
        phase_next   = upd_pkg::PH_IDLE;
        pending_next = pending_reg;
        case (phase_reg)
            upd_pkg::PH_PERCENT: begin
                if (!item_last) begin
                    phase_next   = upd_pkg::PH_PENDING;
                    pending_next = item_byte;
                end
            end
            upd_pkg::PH_PENDING: begin
                if (!pair_ok) begin
                    if (p_pct) begin
                        // The held byte reopens an escape which the new byte extends.
                        if (!item_last) begin
                            phase_next   = upd_pkg::PH_PENDING;
                            pending_next = item_byte;
                        end
                    end else if (b_pct && !item_last) begin
                        phase_next = upd_pkg::PH_PERCENT;
                    end
                end
            end
            default: begin
                if (b_pct && !item_last) begin
                    phase_next = upd_pkg::PH_PERCENT;
                end
            end
        endcase
    end

    // Results of this item, in order.
    always_comb begin
        results       = '0;
        results.count = '0;
        case (phase_reg)
            upd_pkg::PH_PERCENT: begin
                if (item_last) begin
                    results.count        = 2'd2;
                    results.item[0].data = upd_pkg::CH_QUEST;
                    results.item[0].last = 1'b0;
                    results.item[1].data = upd_pkg::plain_out(item_byte);
                    results.item[1].last = 1'b1;
                end
            end
            upd_pkg::PH_PENDING: begin
                if (pair_ok) begin
                    results.count        = 2'd1;
                    results.item[0].data = {hi_nib[3:0], lo_nib[3:0]};
                    results.item[0].last = item_last;
                end else begin
                    results.item[0].data = upd_pkg::CH_QUEST;
                    results.item[0].last = 1'b0;
                    if (p_pct) begin
                        if (item_last) begin
                            results.count        = 2'd3;
                            results.item[1].data = upd_pkg::CH_QUEST;
                            results.item[1].last = 1'b0;
                            results.item[2].data = upd_pkg::plain_out(item_byte);
                            results.item[2].last = 1'b1;
                        end else begin
                            results.count = 2'd1;
                        end
                    end else begin
                        results.item[1].data = upd_pkg::plain_out(pending_reg);
                        results.item[1].last = 1'b0;
                        if (b_pct && !item_last) begin
                            results.count = 2'd2;
                        end else begin
                            results.count        = 2'd3;
                            results.item[2].data = upd_pkg::plain_out(item_byte);
                            results.item[2].last = item_last;
                        end
                    end
                end
            end
            default: begin
                if (!b_pct || item_last) begin
                    results.count        = 2'd1;
                    results.item[0].data = upd_pkg::plain_out(item_byte);
                    results.item[0].last = item_last;
                end
            end
        endcase
    end

endmodule

### hw/rtl/upd_result_queue.sv
module upd_result_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  upd_pkg::bundle_t  push_bundle,
    input  logic              push,
    output logic              space_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_last
);

    upd_pkg::result_t [upd_pkg::QUEUE_DEPTH-1:0] entry_reg;

    logic [upd_pkg::PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [upd_pkg::PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [upd_pkg::FILL_W-1:0] fill_reg, fill_next;
    logic [upd_pkg::FILL_W-1:0] free_slots;
    logic [upd_pkg::FILL_W-1:0] push_count;
    logic                       pop;

    assign free_slots = upd_pkg::FILL_W'(upd_pkg::QUEUE_DEPTH) - fill_reg;
    assign push_count = push ? upd_pkg::FILL_W'(push_bundle.count) : '0;
    assign space_ok   = free_slots >= upd_pkg::FILL_W'(push_bundle.count);
    assign out_valid  = (fill_reg != '0);
    assign pop        = out_valid && out_ready;
    assign out_byte   = entry_reg[rd_ptr_reg].data;
    assign out_last   = entry_reg[rd_ptr_reg].last;

    // Pointers wrap naturally because the depth is a power of two.
    assign wr_ptr_next = wr_ptr_reg + upd_pkg::PTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + upd_pkg::PTR_W'(pop);
    assign fill_next   = fill_reg + push_count - upd_pkg::FILL_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < upd_pkg::MAX_RESULTS; i++) begin
            if (push && (upd_pkg::FILL_W'(i) < push_count)) begin
                entry_reg[wr_ptr_reg + upd_pkg::PTR_W'(i)] <= push_bundle.item[i];
            end
        end
    end

endmodule

### tb/url_percent_decoder_test.sv
module url_percent_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import upd_pkg::*;

    // One encoded item as it waits to go to the decoder.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } encoded_t;

    localparam int STRING_BYTES = 450;
    localparam int TAIL_ITEMS   = 60;
    localparam int SHOW_LIMIT   = 10;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte  = 8'h00;
    logic       s_in_last  = 1'b0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_out_byte;
    logic       m_out_last;

    // Items still to be sent and decoded characters still to arrive.
    encoded_t encoded_q[$];
    result_t  expected_chars[$];

    // The decoder state as the checker sees it.
    phase_t     esc_phase = PH_IDLE;
    logic [7:0] held_byte = 8'h00;

    int fail_count = 0;

    // Idling: each side keeps a busy level that changes now and then; level zero
    // gives long stretches with no idling at all.
    int send_gap   = 0;
    int send_level = 2;
    int hold_gap   = 0;
    int hold_level = 2;

    always #4 aclk = ~aclk;

    url_percent_decoder i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .s_in_last  (s_in_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

    // No new idle burst starts on either side in the last part of the run.
    function automatic logic calm_tail();
        return encoded_q.size() < TAIL_ITEMS;
    endfunction

    // Decides whether an idle burst starts now, given a busy level of 0 to 3.
    function automatic int pick_burst(input int level);
        if (!calm_tail() && level != 0 && $urandom_range(15) < 2 * level) begin
            return $urandom_range(16, 1);
        end
        return 0;
    endfunction

    function automatic void push_char(input logic [7:0] c, input logic last);
        result_t r;
        r.data = c;
        r.last = last;
        expected_chars.push_back(r);
    endfunction

    // Value of a hex digit in the low four bits, with bit 4 set for anything
    // else. Setting bit 5 folds upper-case letters onto lower case, and no
    // other byte lands in the a..f range that way.
    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [7:0] folded;
        logic [7:0] v;
        folded = c | 8'h20;
        v = 8'hFF;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - CH_0;
        end else if (folded >= CH_LA && folded <= CH_LF) begin
            v = folded - CH_LA + 8'd10;
        end
        return (v < 8'd16) ? {1'b0, v[3:0]} : 5'h10;
    endfunction

    // A byte arriving with no escape open. A percent opens one, unless it is
    // the last byte of the string, where it can only be reported as broken.
    function automatic void take_plain(input logic [7:0] c, input logic last);
        if (c == CH_PERCENT) begin
            if (last) begin
                push_char(CH_QUEST, 1'b1);
            end else begin
                esc_phase = PH_PERCENT;
            end
        end else if (c == CH_PLUS) begin
            push_char(CH_SPACE, last);
        end else begin
            push_char(c, last);
        end
    endfunction

    // A byte arriving straight after a percent. If the string ends here the
    // escape is cut short and the byte is decoded again on its own.
    function automatic void take_after_percent(input logic [7:0] c, input logic last);
        if (last) begin
            push_char(CH_QUEST, 1'b0);
            esc_phase = PH_IDLE;
            take_plain(c, 1'b1);
        end else begin
            held_byte = c;
            esc_phase = PH_PENDING;
        end
    endfunction

    // Works out every decoded character that one accepted item gives, and
    // moves the escape state on.
    function automatic void decode_byte(input logic [7:0] c, input logic last);
        logic [7:0] first;
        logic [4:0] hi;
        logic [4:0] lo;
        case (esc_phase)
            PH_PERCENT: begin
                take_after_percent(c, last);
            end
            PH_PENDING: begin
                first = held_byte;
                hi = digit_value(first);
                lo = digit_value(c);
                esc_phase = PH_IDLE;
                if (!hi[4] && !lo[4]) begin
                    push_char({hi[3:0], lo[3:0]}, last);
                end else begin
                    // A bad pair: both bytes are decoded again, and the first
                    // of them may itself open a fresh escape.
                    push_char(CH_QUEST, 1'b0);
                    take_plain(first, 1'b0);
                    if (esc_phase == PH_PERCENT) begin
                        take_after_percent(c, last);
                    end else begin
                        take_plain(c, last);
                    end
                end
            end
            default: begin
                esc_phase = PH_IDLE;
                take_plain(c, last);
            end
        endcase
    endfunction

    function automatic void queue_byte(input logic [7:0] c, input logic last);
        encoded_t e;
        e.code = c;
        e.last = last;
        encoded_q.push_back(e);
    endfunction

    // Queues a whole string, marking its final byte.
    function automatic void queue_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            queue_byte(s[i], i == s.len() - 1);
        end
    endfunction

    // A hex digit character for a value, letters in either case.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_0 + {4'd0, v};
        end
        return ($urandom_range(1) ? CH_UA : CH_LA) + {4'd0, v} - 8'd10;
    endfunction

    // Any byte the input allows; a zero byte never travels on this interface.
    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255, 1));
    endfunction

    // Random strings built mostly from well-formed escapes, with plus signs,
    // stray percents, corrupted pairs and arbitrary bytes mixed in.
    task automatic queue_random_strings();
        logic [7:0] text[$];
        int total;
        int pieces;
        total = 0;
        while (total < STRING_BYTES) begin
            text.delete();
            pieces = $urandom_range(6, 1);
            repeat (pieces) begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4, 5, 6, 7: begin
                        text.push_back(CH_PERCENT);
                        text.push_back(($urandom_range(9) == 0) ? any_byte()
                                       : hex_digit(4'($urandom_range(15))));
                        text.push_back(($urandom_range(9) == 0) ? any_byte()
                                       : hex_digit(4'($urandom_range(15))));
                    end
                    8, 9, 10: begin
                        text.push_back(CH_PLUS);
                    end
                    11, 12: begin
                        text.push_back(CH_PERCENT);
                    end
                    default: begin
                        text.push_back(any_byte());
                    end
                endcase
            end
            foreach (text[i]) begin
                queue_byte(text[i], i == text.size() - 1);
            end
            total += text.size();
        end
    endtask

    // Driver. The decoder's answer to an item is predicted at the edge where
    // the item is accepted; a new item, or an idle cycle, follows whenever the
    // channel is free. Valid is only ever lowered when no item is held.
    always @(posedge aclk) begin
        encoded_t next_item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte, s_in_last);
            end
            if (!s_valid || s_ready) begin
                if ($urandom_range(99) == 0) begin
                    send_level = $urandom_range(3);
                end
                if (send_gap == 0) begin
                    send_gap = pick_burst(send_level);
                end
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (encoded_q.size() > 0) begin
                    next_item = encoded_q.pop_front();
                    s_valid   <= 1'b1;
                    s_in_byte <= next_item.code;
                    s_in_last <= next_item.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each accepted result is held against the oldest decoded
    // character still waiting; the ready line stalls in bursts.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    if (fail_count < SHOW_LIMIT) begin
                        $display("unexpected result: byte %02h last %0d",
                                 m_out_byte, m_out_last);
                    end
                    fail_count++;
                end else begin
                    want = expected_chars.pop_front();
                    if (m_out_byte !== want.data || m_out_last !== want.last) begin
                        if (fail_count < SHOW_LIMIT) begin
                            $display({"mismatch: expected byte %02h last %0d,",
                                      " got byte %02h last %0d"},
                                     want.data, want.last, m_out_byte, m_out_last);
                        end
                        fail_count++;
                    end
                end
            end
            if ($urandom_range(99) == 0) begin
                hold_level = $urandom_range(3);
            end
            if (hold_gap == 0) begin
                hold_gap = pick_burst(hold_level);
            end
            if (hold_gap > 0) begin
                hold_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Stimulus and the end of the run.
    initial begin
        // Directed strings: a plus sign, an escape of zero, the top byte value
        // in mixed case, an upper-case escape, three percents cut off by the
        // end, a bad pair followed by a good escape, a percent with one byte at
        // the end, a lone trailing percent, and the smallest and largest bytes.
        queue_text("+");
        queue_text("%00");
        queue_text("%fF");
        queue_text("%A9");
        queue_text("%%%");
        queue_text("%9%41");
        queue_text("%G");
        queue_text("a%");
        queue_text("%");
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_random_strings();

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (encoded_q.size() != 0 || s_valid) @(posedge aclk);
        while (expected_chars.size() != 0) @(posedge aclk);
        // The wait below shows up any stray result the decoder still sends.
        repeat (20) @(posedge aclk);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this time.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
